// ===== design/etc1_pkg.sv =====
// Shared types and constants for the ETC1 tile decoder.
// Holds the transaction payload structs, the pipeline stage structs and the modifier table.
// Depends on nothing; every design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package etc1_pkg;

  localparam int unsigned TexelsPerSubtile = 16;

  // Bit positions inside the little-endian ETC1 colour word.
  localparam int unsigned NegBase  = 16;
  localparam int unsigned FlipBit  = 32;
  localparam int unsigned DiffBit  = 33;

  typedef struct packed {
    logic [1:0]  subtile;
    logic [63:0] color_word;
    logic [63:0] alpha_word;
  } in_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } out_t;

  // After texel selection: raw codes of the chosen sub-block.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] column;
    logic       last;
    logic       diff;
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
    logic [2:0] tidx;
    logic       col;
    logic       neg;
    logic [3:0] alpha;
  } sel_t;

  // After expansion: 8-bit base colour and signed modifier.
  typedef struct packed {
    logic [2:0]        row;
    logic [2:0]        column;
    logic              last;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic signed [8:0] modifier;
    logic [7:0]        alpha;
  } exp_t;

  // Fixed ETC1 modifier table, magnitude only.
  function automatic logic [7:0] mod_magnitude(input logic [2:0] tidx, input logic col);
    logic [7:0] lo;
    logic [7:0] hi;
    begin
      unique case (tidx)
        3'd0: begin lo = 8'd2;  hi = 8'd8;   end
        3'd1: begin lo = 8'd5;  hi = 8'd17;  end
        3'd2: begin lo = 8'd9;  hi = 8'd29;  end
        3'd3: begin lo = 8'd13; hi = 8'd42;  end
        3'd4: begin lo = 8'd18; hi = 8'd60;  end
        3'd5: begin lo = 8'd24; hi = 8'd80;  end
        3'd6: begin lo = 8'd33; hi = 8'd106; end
        default: begin lo = 8'd47; hi = 8'd183; end
      endcase
      return col ? hi : lo;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/etc1_tile_decoder.sv =====
// ETC1 tile decoder top level: subtile holding register, texel counter and decode pipeline.
// Depends on etc1_pkg for payload types, stage structs and the modifier table.
`timescale 1ns / 1ps
`default_nettype none

// One input transaction carries a 4x4 ETC1 subtile of an 8x8 tile (position, 64-bit colour
// word and 64-bit alpha word); the block answers with sixteen output transactions, one RGBA8
// texel each, in column-outer, row-inner order, with last set on the sixteenth. On the output
// side one texel leaves per cycle while the output is not stalled, paced by the texel counter
// that walks the held subtile. The next subtile is accepted in the cycle its predecessor's
// last texel enters the pipeline, so a steady stream of subtiles keeps the output busy every
// cycle. The accepting edge loads the holding register; the first texel is offered after texel
// selection, colour expansion with table lookup, and the add-and-clamp stage that is also the
// output register. A stalled output freezes the whole pipeline, so nothing is dropped or
// repeated. The alpha_present register is written through cfg_we_i/cfg_data_i and should
// only change while the block is idle; when clear, every alpha is 255.

module etc1_tile_decoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire etc1_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output etc1_pkg::out_t      out_data_o
);

  // Configuration register.
  logic alpha_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      alpha_present_q <= cfg_data_i;
    end
  end

  // Pipeline advance: every stage moves when the output register is free or being taken.
  logic adv;
  assign adv = !out_valid_o || out_ready_i;

  // Holding register and texel counter. The counter value is 4*x + y.
  etc1_pkg::in_t hold_q;
  logic          hold_valid_q;
  logic [3:0]    cnt_q;
  logic          issue;
  logic          issue_last;
  logic          in_acc;

  assign issue      = hold_valid_q && adv;
  assign issue_last = issue && (cnt_q == 4'(etc1_pkg::TexelsPerSubtile - 1));
  // The holding register frees up as soon as its last texel is issued.
  assign in_ready_o = !hold_valid_q || issue_last;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (in_acc) begin
        hold_valid_q <= 1'b1;
        cnt_q        <= '0;
      end else if (issue) begin
        hold_valid_q <= !issue_last;
        cnt_q        <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q <= in_data_i;
    end
  end

  // Stage 1: pick the sub-block of the current texel and its raw codes.
  etc1_pkg::sel_t sel_d, sel_q;
  logic           sel_valid_q;

  always_comb begin
    logic [1:0]  tx;
    logic [1:0]  ty;
    logic        flip;
    logic        blk;
    logic [63:0] cw;
    logic [63:0] aw;
    cw   = hold_q.color_word;
    aw   = alpha_present_q ? hold_q.alpha_word : '1;
    tx   = cnt_q[3:2];
    ty   = cnt_q[1:0];
    flip = cw[etc1_pkg::FlipBit];
    // Columns 0-1 (or rows 0-1 when flipped) belong to the first sub-block.
    blk  = flip ? ty[1] : tx[1];

    sel_d.row    = {hold_q.subtile[1], ty};
    sel_d.column = {hold_q.subtile[0], tx};
    sel_d.last   = (cnt_q == 4'(etc1_pkg::TexelsPerSubtile - 1));
    sel_d.diff   = cw[etc1_pkg::DiffBit];
    sel_d.tidx   = blk ? cw[36:34] : cw[39:37];
    sel_d.col    = cw[{2'b00, cnt_q}];
    sel_d.neg    = cw[6'(etc1_pkg::NegBase) + {2'b00, cnt_q}];
    sel_d.alpha  = aw[{cnt_q, 2'b00} +: 4];

    if (sel_d.diff) begin
      // The second sub-block adds a signed 3-bit delta, wrapping at 5 bits.
      if (blk) begin
        sel_d.red   = cw[63:59] + {{2{cw[58]}}, cw[58:56]};
        sel_d.green = cw[55:51] + {{2{cw[50]}}, cw[50:48]};
        sel_d.blue  = cw[47:43] + {{2{cw[42]}}, cw[42:40]};
      end else begin
        sel_d.red   = cw[63:59];
        sel_d.green = cw[55:51];
        sel_d.blue  = cw[47:43];
      end
    end else begin
      if (blk) begin
        sel_d.red   = {1'b0, cw[59:56]};
        sel_d.green = {1'b0, cw[51:48]};
        sel_d.blue  = {1'b0, cw[43:40]};
      end else begin
        sel_d.red   = {1'b0, cw[63:60]};
        sel_d.green = {1'b0, cw[55:52]};
        sel_d.blue  = {1'b0, cw[47:44]};
      end
    end
  end

  // Stage 2: expand the colour codes to 8 bits and look up the signed modifier.
  etc1_pkg::exp_t exp_d, exp_q;
  logic           exp_valid_q;

  always_comb begin
    logic [8:0] mag;
    mag          = {1'b0, etc1_pkg::mod_magnitude(sel_q.tidx, sel_q.col)};
    exp_d.row    = sel_q.row;
    exp_d.column = sel_q.column;
    exp_d.last   = sel_q.last;
    exp_d.alpha  = {sel_q.alpha, sel_q.alpha};
    exp_d.modifier = sel_q.neg ? -$signed(mag) : $signed(mag);
    if (sel_q.diff) begin
      exp_d.red   = {sel_q.red,   sel_q.red[4:2]};
      exp_d.green = {sel_q.green, sel_q.green[4:2]};
      exp_d.blue  = {sel_q.blue,  sel_q.blue[4:2]};
    end else begin
      exp_d.red   = {sel_q.red[3:0],   sel_q.red[3:0]};
      exp_d.green = {sel_q.green[3:0], sel_q.green[3:0]};
      exp_d.blue  = {sel_q.blue[3:0],  sel_q.blue[3:0]};
    end
  end

  // Stage 3: add the modifier with clamping to 0..255; this is the output register.
  function automatic logic [7:0] clamp_add(input logic [7:0] base,
                                           input logic signed [8:0] modifier);
    logic signed [9:0] sum;
    begin
      sum = $signed({2'b00, base}) + 10'(modifier);
      if (sum[9]) begin
        return 8'd0;
      end else if (sum[8]) begin
        return 8'hFF;
      end else begin
        return sum[7:0];
      end
    end
  endfunction

  etc1_pkg::out_t out_d, out_q;
  logic           out_valid_q;

  always_comb begin
    out_d.row    = exp_q.row;
    out_d.column = exp_q.column;
    out_d.last   = exp_q.last;
    out_d.alpha  = exp_q.alpha;
    out_d.red    = clamp_add(exp_q.red,   exp_q.modifier);
    out_d.green  = clamp_add(exp_q.green, exp_q.modifier);
    out_d.blue   = clamp_add(exp_q.blue,  exp_q.modifier);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      exp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      sel_valid_q <= hold_valid_q;
      exp_valid_q <= sel_valid_q;
      out_valid_q <= exp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_q <= sel_d;
      exp_q <= exp_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/etc1_chk.sv =====
// Port-level checker for the ETC1 tile decoder, bound to the top level.
// Depends on etc1_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

module etc1_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           cfg_we_i,
  input wire logic           cfg_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire etc1_pkg::out_t out_data_o
);

  // Shadow of the alpha_present register as seen on the port.
  logic alpha_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_on_q <= 1'b0;
    end else if (cfg_we_i) begin
      alpha_on_q <= cfg_data_i;
    end
  end

  // A stalled texel stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // The last texel of a subtile is its bottom-right corner.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.row[1:0] == 2'd3 && out_data_o.column[1:0] == 2'd3)
    else $error("last flag on a texel that is not the final one");

  // The bottom-right texel always carries the last flag.
  a_corner_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.row[1:0] == 2'd3 && out_data_o.column[1:0] == 2'd3 |->
      out_data_o.last)
    else $error("final texel without last flag");

  // Without alpha data every texel is opaque.
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !alpha_on_q |-> out_data_o.alpha == 8'hFF)
    else $error("alpha not opaque while alpha is absent");

  // Alpha is a nibble replicated into both halves.
  a_alpha_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.alpha[7:4] == out_data_o.alpha[3:0])
    else $error("alpha is not a replicated nibble");

endmodule

bind etc1_tile_decoder etc1_chk u_etc1_chk (.*);

`default_nettype wire

// ===== tb/etc1_tile_decoder_test.sv =====
// Self-checking testbench for the ETC1 tile decoder: subtiles in, sixteen RGBA8 texels out.
// Depends on etc1_pkg for the payload structs and word layout constants, and on the RTL top.
`timescale 1ns / 1ps

module etc1_tile_decoder_test;

  // Modifier magnitudes of the ETC1 intensity table, indexed by the 3-bit table code.
  // The near step is used when a texel's column select bit is clear, the far step otherwise.
  localparam logic [0:7][7:0] NearStep = {8'd2, 8'd5, 8'd9, 8'd13, 8'd18, 8'd24, 8'd33, 8'd47};
  localparam logic [0:7][7:0] FarStep  = {8'd8, 8'd17, 8'd29, 8'd42, 8'd60, 8'd80, 8'd106, 8'd183};

  localparam int MaxReported = 10;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           cfg_we_i    = 1'b0;
  logic           cfg_data_i  = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  etc1_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  etc1_pkg::out_t out_data_o;

  // Subtiles waiting to be offered, and texels predicted for subtiles already accepted.
  etc1_pkg::in_t  pending_subtiles[$];
  etc1_pkg::out_t expected_texels[$];

  // Shadow of the alpha_present register; only changes while the block is idle.
  logic alpha_on = 1'b0;

  // Idle percentages of the two channels, changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // The driver counts subtiles it has put on the bus, the monitor counts accepted ones.
  int unsigned offered_count  = 0;
  int unsigned accepted_count = 0;

  int unsigned fail_count     = 0;
  int unsigned texels_checked = 0;
  int unsigned diff_subtiles  = 0;
  int unsigned flip_subtiles  = 0;

  etc1_tile_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 2 ns clock period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Saturate a signed sum to the 0..255 range of a colour channel.
  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return 8'(v);
  endfunction

  // Expand one accepted subtile into its sixteen texels and queue them in output order:
  // column-outer, row-inner inside the subtile, last flagged on the sixteenth.
  function automatic void predict_texels(input etc1_pkg::in_t sub);
    logic [63:0]    cw;
    logic [7:0]     base [2][3];
    logic [2:0]     tidx [2];
    logic [4:0]     v5;
    int             c;
    int             x;
    int             y;
    int             t;
    int             blk;
    int             mod;
    etc1_pkg::out_t texel;
    cw = sub.color_word;
    tidx[0] = cw[39:37];
    tidx[1] = cw[36:34];
    // Channels red, green and blue sit one byte apart, red highest.
    for (c = 0; c < 3; c++) begin
      if (cw[etc1_pkg::DiffBit]) begin
        v5 = cw[59 - 8 * c +: 5];
        base[0][c] = {v5, v5[4:2]};
        // The second base is the first plus a signed 3-bit delta, wrapped to 5 bits.
        v5 = v5 + {{2{cw[58 - 8 * c]}}, cw[56 - 8 * c +: 3]};
        base[1][c] = {v5, v5[4:2]};
      end else begin
        base[0][c] = {2{cw[60 - 8 * c +: 4]}};
        base[1][c] = {2{cw[56 - 8 * c +: 4]}};
      end
    end
    for (x = 0; x < 4; x++) begin
      for (y = 0; y < 4; y++) begin
        t = 4 * x + y;
        // Without flip the sub-blocks split the subtile into left and right halves,
        // with flip into top and bottom halves.
        blk = ((cw[etc1_pkg::FlipBit] ? y : x) >= 2) ? 1 : 0;
        mod = cw[t] ? int'(FarStep[tidx[blk]]) : int'(NearStep[tidx[blk]]);
        if (cw[etc1_pkg::NegBase + t]) begin
          mod = -mod;
        end
        texel.row    = {sub.subtile[1], y[1:0]};
        texel.column = {sub.subtile[0], x[1:0]};
        texel.red    = clamp_byte(int'(base[blk][0]) + mod);
        texel.green  = clamp_byte(int'(base[blk][1]) + mod);
        texel.blue   = clamp_byte(int'(base[blk][2]) + mod);
        texel.alpha  = alpha_on ? {2{sub.alpha_word[4 * t +: 4]}} : 8'hFF;
        texel.last   = (t == 15);
        expected_texels.push_back(texel);
      end
    end
  endfunction

  // Assemble an ETC1 colour word from its fields, highest bits first.
  function automatic logic [63:0] etc1_word(input logic [23:0] colors, input logic [2:0] t1,
                                            input logic [2:0] t2, input logic diff,
                                            input logic flip, input logic [15:0] neg,
                                            input logic [15:0] sel);
    return {colors, t1, t2, diff, flip, neg, sel};
  endfunction

  // Random subtile with fully random words; some get extreme base colours so that the
  // clamp is hit from both sides, and some get an all-zero or all-one alpha word.
  function automatic etc1_pkg::in_t random_subtile();
    etc1_pkg::in_t s;
    s.subtile    = 2'($urandom_range(3));
    s.color_word = {$urandom, $urandom};
    s.alpha_word = {$urandom, $urandom};
    case ($urandom_range(7))
      0: begin
        s.color_word[63:40] = '0;
      end
      1: begin
        s.color_word[63:40] = '1;
      end
      2: begin
        s.alpha_word = $urandom_range(1) ? '0 : '1;
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // The stimulus process works half a nanosecond after each rising edge, where neither the
  // driver nor the monitor is active, so its queue and register updates never race them.
  task automatic settle();
    @(posedge clk_i);
    #0.5;
  endtask

  // Block until every queued subtile has been accepted and every predicted texel has arrived.
  task automatic wait_drained();
    while (pending_subtiles.size() != 0 || in_valid_i || expected_texels.size() != 0) begin
      settle();
    end
  endtask

  // The register is written at the rising edge inside settle(); the block is idle here.
  task automatic set_alpha_present(input logic on);
    cfg_data_i = on;
    cfg_we_i   = 1'b1;
    settle();
    cfg_we_i   = 1'b0;
    alpha_on   = on;
  endtask

  // Driver: inputs change on the falling edge. A new subtile is offered only once the current
  // transaction has been accepted, and valid is driven by a single assignment per edge.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && accepted_count != offered_count)) begin
      if (pending_subtiles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i     <= pending_subtiles.pop_front();
        in_valid_i    <= 1'b1;
        offered_count =  offered_count + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: both channels are sampled on the rising edge. An accepted subtile is predicted at
  // once with the current register value; each texel transaction is checked against the
  // oldest prediction, field by field.
  always @(posedge clk_i) begin
    etc1_pkg::out_t want;
    logic           bad;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_texels(in_data_i);
        accepted_count = accepted_count + 1;
        diff_subtiles  += in_data_i.color_word[etc1_pkg::DiffBit];
        flip_subtiles  += in_data_i.color_word[etc1_pkg::FlipBit];
      end
      if (out_valid_o && out_ready_i) begin
        texels_checked++;
        if (expected_texels.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReported) begin
            $display("%0t: texel r%0d c%0d with nothing expected", $realtime,
                     out_data_o.row, out_data_o.column);
          end
        end else begin
          want = expected_texels.pop_front();
          bad = (out_data_o.row !== want.row) || (out_data_o.column !== want.column) ||
                (out_data_o.red !== want.red) || (out_data_o.green !== want.green) ||
                (out_data_o.blue !== want.blue) || (out_data_o.alpha !== want.alpha) ||
                (out_data_o.last !== want.last);
          if (bad) begin
            fail_count++;
            if (fail_count <= MaxReported) begin
              $display("%0t: texel mismatch, expected r%0d c%0d rgba %h %h %h %h last %b",
                       $realtime, want.row, want.column, want.red, want.green, want.blue,
                       want.alpha, want.last);
              $display("             got      r%0d c%0d rgba %h %h %h %h last %b",
                       out_data_o.row, out_data_o.column, out_data_o.red, out_data_o.green,
                       out_data_o.blue, out_data_o.alpha, out_data_o.last);
            end
          end
        end
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    int i;
    repeat (12) @(posedge clk_i);
    #0.5;
    rst_ni = 1'b1;

    // Phase one: register at its reset value, so alpha is absent. Slow sender, slower
    // receiver. Directed subtiles cover the word extremes, both colour modes, both flips,
    // every table code, clamping at both ends and the wrap of a differential base.
    send_idle_pct = 33;
    recv_idle_pct = 64;
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd0, 64'h0, 64'h0});
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd3, '1, '1});
    // Black bases with every modifier negated clamp at zero.
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd1,
        etc1_word(24'h000000, 3'd7, 3'd7, 1'b0, 1'b0, 16'hFFFF, 16'hA5A5), 64'h0});
    // White bases with positive modifiers clamp at 255.
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd2,
        etc1_word(24'hFFFFFF, 3'd7, 3'd6, 1'b0, 1'b1, 16'h0000, 16'h5A5A), '1});
    // Differential sums that run past 31 and wrap around.
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd0,
        etc1_word({5'd31, 3'd3, 5'd30, 3'd3, 5'd31, 3'd1}, 3'd0, 3'd3, 1'b1, 1'b0,
                  16'h00FF, 16'h0F0F), 64'h0});
    // Differential sums that drop below zero and wrap around.
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd1,
        etc1_word({5'd0, 3'd4, 5'd1, 3'd5, 5'd2, 3'd4}, 3'd4, 3'd5, 1'b1, 1'b1,
                  16'hF0F0, 16'h3333), 64'h0});
    for (i = 0; i < 8; i++) begin
      pending_subtiles.push_back(etc1_pkg::in_t'{2'(i),
          etc1_word(24'($urandom), 3'(i), 3'(7 - i), i[0], i[1], 16'($urandom),
                    16'($urandom)), {$urandom, $urandom}});
    end
    wait_drained();

    // Phase two: alpha present, same pacing. Alpha words at their extremes and with every
    // nibble value once, then random subtiles.
    set_alpha_present(1'b1);
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd2, {$urandom, $urandom}, 64'h0});
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd1, {$urandom, $urandom}, '1});
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd3, {$urandom, $urandom},
                                               64'h0123456789ABCDEF});
    pending_subtiles.push_back(etc1_pkg::in_t'{2'd0, 64'h0, 64'hFEDCBA9876543210});
    for (i = 0; i < 130; i++) begin
      pending_subtiles.push_back(random_subtile());
    end
    wait_drained();

    // Phase three: alpha absent again, pacing swapped. After sixty subtiles the sender holds back
    // until the block has delivered every texel, so it restarts from a fully empty pipeline.
    set_alpha_present(1'b0);
    send_idle_pct = 64;
    recv_idle_pct = 33;
    for (i = 0; i < 60; i++) begin
      pending_subtiles.push_back(random_subtile());
    end
    wait_drained();
    for (i = 0; i < 70; i++) begin
      pending_subtiles.push_back(random_subtile());
    end
    wait_drained();

    // Phase four: alpha present, both sides at full rate to keep the output busy every cycle.
    set_alpha_present(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < 140; i++) begin
      pending_subtiles.push_back(random_subtile());
    end
    wait_drained();

    // Let any stray texel appear from the selection, expansion and output stages.
    repeat (32) @(posedge clk_i);
    $display("Decoded %0d subtiles (%0d differential, %0d flipped), %0d texels checked.",
             accepted_count, diff_subtiles, flip_subtiles, texels_checked);
    $display("Alpha was both present and absent, under three pacing profiles.");
    if (fail_count == 0) begin
      $display("[etc1_tile_decoder] OK");
    end else begin
      $display("%0d texel transactions failed their check.", fail_count);
      $display("[etc1_tile_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog: stops a run that does not finish in time and reports it as an error.
  initial begin
    #2000000;
    $display("Run did not finish in time: %0d texels still expected.", expected_texels.size());
    $display("[etc1_tile_decoder] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/etc1_pkg.sv
design/etc1_tile_decoder.sv
design/etc1_chk.sv
tb/etc1_tile_decoder_test.sv
